// ===== hw/rtl/lmps_pkg.sv =====
// shared constants, command codes and result word type for the led matrix scan driver
package lmps_pkg;

  localparam int NUM_COLUMNS = 4;
  localparam int NUM_LINES   = 5;
  localparam int PWM_STEPS   = 15;

  localparam int LEVEL_W  = 4;
  localparam int POS_W    = 4;
  localparam int CMD_W    = 2;
  localparam int LINE_W   = 5;
  localparam int ENABLE_W = 4;

  localparam int COL_W   = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int PHASE_W = $clog2(PWM_STEPS);
  localparam int CMP_W   = (PHASE_W > LEVEL_W) ? PHASE_W : LEVEL_W;
  localparam int LN_ALL_W = (NUM_LINES > LINE_W) ? NUM_LINES : LINE_W;
  localparam int EN_ALL_W = (NUM_COLUMNS > ENABLE_W) ? NUM_COLUMNS : ENABLE_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FILL  = 2'd2,
    CMD_FLIP  = 2'd3
  } cmd_t;

  typedef logic [LEVEL_W-1:0] level_t;

  typedef struct packed {
    logic [LINE_W-1:0]   line_drive;
    logic [ENABLE_W-1:0] column_enable_n;
  } res_t;

endpackage

// ===== hw/rtl/lmps_core.sv =====
// pixel buffers, pwm phase and column scan state with result word computation
module lmps_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc,
  input  logic [lmps_pkg::CMD_W-1:0] cmd,
  input  logic signed [lmps_pkg::POS_W-1:0] pos_x,
  input  logic signed [lmps_pkg::POS_W-1:0] pos_y,
  input  logic [lmps_pkg::LEVEL_W-1:0] pixel_level,
  output lmps_pkg::res_t             res
);
  import lmps_pkg::*;

  localparam logic [COL_W-1:0]   COL_LAST   = COL_W'(NUM_COLUMNS - 1);
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PWM_STEPS - 1);

  level_t draw_r  [NUM_LINES][NUM_COLUMNS];
  level_t shown_r [NUM_LINES][NUM_COLUMNS];
  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ENABLE_W-1:0] enable_hold_r, enable_hold_nxt;
  logic [LINE_W-1:0]   line_hold_r, line_hold_nxt;

  logic                is_tick;
  logic                x_ok, y_ok;
  logic [LN_ALL_W-1:0] lines_all;
  logic [EN_ALL_W-1:0] en_all;

  assign is_tick = (cmd == CMD_TICK);
  assign x_ok = !pos_x[POS_W-1] && ({1'b0, pos_x} < (POS_W+1)'(NUM_COLUMNS));
  assign y_ok = !pos_y[POS_W-1] && ({1'b0, pos_y} < (POS_W+1)'(NUM_LINES));

  always_comb begin
    lines_all = '0;
    for (int l = 0; l < NUM_LINES; l++) begin
      lines_all[l] = CMP_W'(shown_r[l][col_r]) > CMP_W'(phase_r);
    end
    en_all = '0;
    for (int c = 0; c < NUM_COLUMNS; c++) begin
      en_all[c] = (col_r != COL_W'(c));
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    col_nxt         = col_r;
    enable_hold_nxt = enable_hold_r;
    line_hold_nxt   = line_hold_r;
    if (is_tick) begin
      if (phase_r == '0) begin
        enable_hold_nxt = en_all[ENABLE_W-1:0];
      end
      line_hold_nxt = lines_all[LINE_W-1:0];
      if (phase_r == PHASE_LAST) begin
        phase_nxt = '0;
        col_nxt   = (col_r == COL_LAST) ? '0 : col_r + 1'b1;
      end else begin
        phase_nxt = phase_r + 1'b1;
      end
    end
  end

  assign res.line_drive      = line_hold_nxt;
  assign res.column_enable_n = enable_hold_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PHASE_W'(1);
      col_r         <= '0;
      enable_hold_r <= '0;
      line_hold_r   <= '0;
      for (int l = 0; l < NUM_LINES; l++) begin
        for (int c = 0; c < NUM_COLUMNS; c++) begin
          draw_r[l][c]  <= '0;
          shown_r[l][c] <= '0;
        end
      end
    end else if (acc) begin
      phase_r       <= phase_nxt;
      col_r         <= col_nxt;
      enable_hold_r <= enable_hold_nxt;
      line_hold_r   <= line_hold_nxt;
      for (int l = 0; l < NUM_LINES; l++) begin
        for (int c = 0; c < NUM_COLUMNS; c++) begin
          unique case (cmd)
            CMD_WRITE: begin
              if (x_ok && y_ok && pos_x == POS_W'(c) && pos_y == POS_W'(l)) begin
                draw_r[l][c] <= pixel_level;
              end
            end
            CMD_FILL: draw_r[l][c] <= pixel_level;
            CMD_FLIP: shown_r[l][c] <= draw_r[l][c];
            default: ;
          endcase
        end
      end
    end
  end

  a_non_tick_holds_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !is_tick) |=> ($stable(phase_r) && $stable(col_r)))
    else $error("scan state moved on a non-tick command");

  a_phase_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_tick && phase_r == PHASE_LAST) |=> (phase_r == '0))
    else $error("pwm phase did not wrap");

  a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_tick && phase_r != PHASE_LAST) |=>
      (phase_r == $past(phase_r) + 1'b1 && $stable(col_r)))
    else $error("pwm phase did not step");

endmodule

// ===== hw/rtl/lmps_out_buf.sv =====
// two-entry output register with skid stage for result words
module lmps_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lmps_pkg::res_t push_data,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output lmps_pkg::res_t out_data
);
  import lmps_pkg::*;

  res_t main_r, skid_r;
  logic main_valid_r, skid_valid_r;
  logic pop;

  assign pop       = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        main_r       <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_r       <= push_data;
        main_valid_r <= 1'b1;
      end else begin
        skid_r       <= push_data;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  a_skid_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid word held without output word");

  a_skid_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (push && main_valid_r && out_stall && !skid_valid_r) |=> skid_valid_r)
    else $error("word lost while output stalled");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> (!skid_valid_r && main_valid_r))
    else $error("skid word not moved to output");

endmodule

// ===== hw/rtl/led_matrix_pwm_scan.sv =====
// top level of the multiplexed led matrix pwm scan driver
// usage:
//   input channel in_valid/in_stall carries one command word: in_cmd selects
//   scan tick, pixel write, fill of the drawing buffer or buffer flip, with
//   in_pos_x, in_pos_y and in_pixel_level as operands
//   output channel out_valid/out_stall returns one word per command:
//   out_line_drive and out_column_enable_n, the held drive state after it
//   a result is registered into the output buffer as its command is accepted
//   throughput: one command per cycle while in_stall is low; all buffer updates,
//   including fill and flip, finish in the accepting cycle since both buffers are flops
//   a stalled receiver fills the output register, then the skid entry;
//   in_stall rises only when both hold words
//   reset: both buffers cleared, pwm phase one, column zero, all enables
//   and lines low, output empty
module led_matrix_pwm_scan (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lmps_pkg::CMD_W-1:0]          in_cmd,
  input  logic signed [lmps_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [lmps_pkg::POS_W-1:0]   in_pos_y,
  input  logic [lmps_pkg::LEVEL_W-1:0]        in_pixel_level,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lmps_pkg::LINE_W-1:0]         out_line_drive,
  output logic [lmps_pkg::ENABLE_W-1:0]       out_column_enable_n
);
  import lmps_pkg::*;

  logic acc;
  logic full;
  res_t res, out_res;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  lmps_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .cmd         (in_cmd),
    .pos_x       (in_pos_x),
    .pos_y       (in_pos_y),
    .pixel_level (in_pixel_level),
    .res         (res)
  );

  lmps_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_line_drive      = out_res.line_drive;
  assign out_column_enable_n = out_res.column_enable_n;

endmodule
